// ===== hw/rtl/command_text_lexer_macros.svh =====
// Assertion macros shared by the lexer modules.
// Each macro samples on the rising edge of clock and is disabled while rst is high.
`ifndef COMMAND_TEXT_LEXER_MACROS_SVH
`define COMMAND_TEXT_LEXER_MACROS_SVH

// Check cons in the same cycle as ante.
`define CMDLX_ASSERT_IMPL(name, rst, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check cons in the cycle after ante.
`define CMDLX_ASSERT_NEXT(name, rst, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/cmdlx_pkg.sv =====
package cmdlx_pkg;

   // Characters that the lexer recognises
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_AT     = 8'h40;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_TILDE  = 8'h7E;
   localparam logic [7:0] CH_LBR    = 8'h5B;
   localparam logic [7:0] CH_RBR    = 8'h5D;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_USCORE = 8'h5F;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_UC_A   = 8'h41;
   localparam logic [7:0] CH_UC_Z   = 8'h5A;
   localparam logic [7:0] CH_LC_A   = 8'h61;
   localparam logic [7:0] CH_LC_Z   = 8'h7A;

   // Depth of the queue between classifier and token engine
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = 2;

   // Character class flags produced by the classifier
   typedef struct packed {
      logic space;
      logic slash;
      logic at;
      logic quote;
      logic bslash;
      logic lbr;
      logic rbr;
      logic digit;
      logic alpha;
      logic colon;
      logic uscore;
      logic dot;
      logic dash;
      logic tilde;
   } class_type;

   localparam int CLS_W = $bits(class_type);

   typedef enum logic [2:0] {
      KIND_NONE    = 3'd0,
      KIND_CMD     = 3'd1,
      KIND_SEL     = 3'd2,
      KIND_STR     = 3'd3,
      KIND_COORD   = 3'd4,
      KIND_BRACKET = 3'd5,
      KIND_ITEM    = 3'd6
   } kind_type;

   typedef enum logic [7:0] {
      MODE_IDLE    = 8'b0000_0001,
      MODE_CMD     = 8'b0000_0010,
      MODE_SEL_AT  = 8'b0000_0100,
      MODE_SEL_BR  = 8'b0000_1000,
      MODE_STR     = 8'b0001_0000,
      MODE_STR_ESC = 8'b0010_0000,
      MODE_COORD   = 8'b0100_0000,
      MODE_ITEM    = 8'b1000_0000
   } mode_type;

   typedef struct packed {
      kind_type    kind;
      logic [11:0] start;
      logic [12:0] length;
      logic        done;
   } rsp_type;

endpackage

// ===== hw/rtl/cmdlx_if.sv =====
// Byte channel into the lexer
interface cmdlx_req_if ();
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       is_final;

   modport source (output valid, char_byte, is_final, input ready);
   modport sink (input valid, char_byte, is_final, output ready);
endinterface

// Token channel out of the lexer
interface cmdlx_rsp_if ();
   logic        valid;
   logic        ready;
   logic [2:0]  token_kind;
   logic [11:0] token_start;
   logic [12:0] token_length;
   logic        text_done;

   modport source (output valid, token_kind, token_start, token_length, text_done,
                   input ready);
   modport sink (input valid, token_kind, token_start, token_length, text_done,
                 output ready);
endinterface

// ===== hw/rtl/cmdlx_front.sv =====
module cmdlx_front import cmdlx_pkg::*; #(
   parameter int MAX_TEXT_BYTES = 4096,
   parameter int OFF_W          = 12,
   parameter int DATA_W         = CLS_W + 13
) (
   input  logic              clock,
   input  logic              reset,
   cmdlx_req_if.sink         req_bus,
   output logic              q_valid,
   input  logic              q_ready,
   output logic [DATA_W-1:0] q_data
);

   localparam logic [OFF_W-1:0] OFF_TOP = OFF_W'(MAX_TEXT_BYTES - 1);

   logic              vld_ff, vld_in;
   logic [DATA_W-1:0] item_ff, item_in;
   logic [OFF_W-1:0]  off_ff, off_in;
   logic              accept;

   function automatic class_type classify(logic [7:0] c);
      class_type k;
      k.space  = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
      k.slash  = (c == CH_SLASH);
      k.at     = (c == CH_AT);
      k.quote  = (c == CH_QUOTE);
      k.bslash = (c == CH_BSLASH);
      k.lbr    = (c == CH_LBR);
      k.rbr    = (c == CH_RBR);
      k.digit  = (c >= CH_ZERO) && (c <= CH_NINE);
      k.alpha  = ((c >= CH_UC_A) && (c <= CH_UC_Z)) || ((c >= CH_LC_A) && (c <= CH_LC_Z));
      k.colon  = (c == CH_COLON);
      k.uscore = (c == CH_USCORE);
      k.dot    = (c == CH_DOT);
      k.dash   = (c == CH_DASH);
      k.tilde  = (c == CH_TILDE);
      return k;
   endfunction

   // Take a byte whenever the stage is empty or drains this cycle
   assign req_bus.ready = !vld_ff || q_ready;
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      vld_in  = accept || (vld_ff && !q_ready);
      item_in = item_ff;
      off_in  = off_ff;
      if (accept) begin
         item_in = {classify(req_bus.char_byte), off_ff, req_bus.is_final};
         // Saturate the offset at the top; restart after the last byte of a text
         if (req_bus.is_final) begin
            off_in = '0;
         end else if (off_ff != OFF_TOP) begin
            off_in = off_ff + OFF_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         off_ff <= '0;
      end else begin
         vld_ff <= vld_in;
         off_ff <= off_in;
      end
      item_ff <= item_in;
   end

   assign q_valid = vld_ff;
   assign q_data  = item_ff;

endmodule

// ===== hw/rtl/cmdlx_queue.sv =====
`include "command_text_lexer_macros.svh"

module cmdlx_queue import cmdlx_pkg::*; #(
   parameter int DATA_W = CLS_W + 13
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [DATA_W-1:0] in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [DATA_W-1:0] out_data
);

   localparam logic [Q_PTR_W:0] FULL_COUNT = (Q_PTR_W + 1)'(Q_DEPTH);

   logic [DATA_W-1:0]  slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_PTR_W:0]   count_ff, count_in;
   logic               push, pop;

   assign in_ready  = (count_ff != FULL_COUNT);
   assign out_valid = (count_ff != '0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + Q_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + Q_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (Q_PTR_W + 1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (Q_PTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming transaction
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

   `CMDLX_ASSERT_IMPL(a_count_bound, reset, 1'b1, count_ff <= FULL_COUNT, "occupancy beyond depth")
   `CMDLX_ASSERT_NEXT(a_push_shows, reset, push && count_ff == '0, out_valid, "push not visible")
   `CMDLX_ASSERT_NEXT(a_head_holds, reset, out_valid && !out_ready, $stable(out_data), "head moved")

endmodule

// ===== hw/rtl/cmdlx_back.sv =====
`include "command_text_lexer_macros.svh"

module cmdlx_back import cmdlx_pkg::*; #(
   parameter int OFF_W  = 12,
   parameter int DATA_W = CLS_W + 13
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_ready,
   input  logic [DATA_W-1:0] q_data,
   cmdlx_rsp_if.source       rsp_bus
);

   localparam int CALC_W = (OFF_W + 1 > 13) ? OFF_W + 1 : 13;
   localparam int SW     = (OFF_W > 12) ? OFF_W : 12;

   mode_type         mode_ff, mode_in;
   logic [OFF_W-1:0] st_ff, st_in;
   rsp_type          out_ff, out_in, pend_ff, pend_in;
   logic             out_vld_ff, out_vld_in, pend_vld_ff, pend_vld_in;

   class_type        cls;
   logic [OFF_W-1:0] off;
   logic             fin;
   logic             pop, out_free, rescan;
   logic             e1_v, e1_incl, e2_v, e3_v, two;
   kind_type         e1_kind, e3_kind;
   rsp_type          e1, e2, e3, r0, r1;

   function automatic logic [12:0] len_of(logic [OFF_W-1:0] s, logic [OFF_W-1:0] o,
                                          logic incl);
      logic [CALC_W-1:0] d;
      d = CALC_W'(o) - CALC_W'(s) + CALC_W'(incl);
      return d[12:0];
   endfunction

   function automatic logic [11:0] start_of(logic [OFF_W-1:0] o);
      logic [SW-1:0] w;
      w = SW'(o);
      return w[11:0];
   endfunction

   assign fin = q_data[0];
   assign off = q_data[OFF_W:1];
   assign cls = class_type'(q_data[DATA_W-1 -: CLS_W]);

   // Take an item only when the pending slot is empty and the output register can absorb a token
   assign out_free = !out_vld_ff || rsp_bus.ready;
   assign q_ready  = !pend_vld_ff && out_free;
   assign pop      = q_valid && q_ready;

   // Close or extend the open token; rescan a byte outside it as a possible token start
   always_comb begin
      mode_in = mode_ff;
      st_in   = st_ff;
      rescan  = 1'b0;
      e1_v    = 1'b0;
      e1_incl = 1'b0;
      e1_kind = KIND_NONE;
      e2_v    = 1'b0;
      case (mode_ff)
         MODE_IDLE: begin
            rescan = 1'b1;
         end
         MODE_CMD: begin
            if (!(cls.digit || cls.alpha || cls.uscore)) begin
               e1_v    = 1'b1;
               e1_kind = KIND_CMD;
               rescan  = 1'b1;
               mode_in = MODE_IDLE;
            end
         end
         MODE_SEL_AT: begin
            if (cls.alpha) begin
               e1_v    = 1'b1;
               e1_incl = 1'b1;
               e1_kind = KIND_SEL;
               mode_in = MODE_IDLE;
            end else if (cls.lbr) begin
               mode_in = MODE_SEL_BR;
            end else begin
               e1_v    = 1'b1;
               e1_kind = KIND_SEL;
               rescan  = 1'b1;
               mode_in = MODE_IDLE;
            end
         end
         MODE_SEL_BR: begin
            if (cls.rbr) begin
               e1_v    = 1'b1;
               e1_incl = 1'b1;
               e1_kind = KIND_SEL;
               mode_in = MODE_IDLE;
            end
         end
         MODE_STR: begin
            if (cls.quote) begin
               e1_v    = 1'b1;
               e1_incl = 1'b1;
               e1_kind = KIND_STR;
               mode_in = MODE_IDLE;
            end else if (cls.bslash) begin
               mode_in = MODE_STR_ESC;
            end
         end
         MODE_STR_ESC: begin
            if (!cls.bslash) begin
               mode_in = MODE_STR;
            end
         end
         MODE_COORD: begin
            if (!(cls.digit || cls.dot || cls.dash)) begin
               e1_v    = 1'b1;
               e1_kind = KIND_COORD;
               rescan  = 1'b1;
               mode_in = MODE_IDLE;
            end
         end
         MODE_ITEM: begin
            if (!(cls.digit || cls.alpha || cls.colon || cls.uscore || cls.dash)) begin
               e1_v    = 1'b1;
               e1_kind = KIND_ITEM;
               rescan  = 1'b1;
               mode_in = MODE_IDLE;
            end
         end
         default: begin
            rescan  = 1'b1;
            mode_in = MODE_IDLE;
         end
      endcase

      if (rescan) begin
         st_in = off;
         if (cls.space) begin
            mode_in = MODE_IDLE;
         end else if (cls.slash) begin
            mode_in = MODE_CMD;
         end else if (cls.at) begin
            mode_in = MODE_SEL_AT;
         end else if (cls.quote) begin
            mode_in = MODE_STR;
         end else if (cls.digit || cls.dash || cls.tilde) begin
            mode_in = MODE_COORD;
         end else if (cls.lbr || cls.rbr) begin
            e2_v = 1'b1;
         end else if (cls.alpha || cls.colon || cls.uscore) begin
            mode_in = MODE_ITEM;
         end
      end
   end

   // Build the candidate tokens: closed token, bracket, and end-of-text flush
   always_comb begin
      case (mode_in)
         MODE_CMD:                 e3_kind = KIND_CMD;
         MODE_SEL_AT, MODE_SEL_BR: e3_kind = KIND_SEL;
         MODE_STR, MODE_STR_ESC:   e3_kind = KIND_STR;
         MODE_COORD:               e3_kind = KIND_COORD;
         default:                  e3_kind = KIND_ITEM;
      endcase

      e1 = '{kind: e1_kind, start: start_of(st_ff), length: len_of(st_ff, off, e1_incl),
             done: 1'b0};
      e2 = '{kind: KIND_BRACKET, start: start_of(off), length: 13'd1, done: 1'b0};
      if (mode_in != MODE_IDLE) begin
         e3 = '{kind: e3_kind, start: start_of(st_in), length: len_of(st_in, off, 1'b1),
                done: 1'b0};
      end else begin
         e3 = '{kind: KIND_NONE, start: 12'd0, length: 13'd0, done: 1'b0};
      end
      e3_v = fin && ((mode_in != MODE_IDLE) || (!e1_v && !e2_v));

      // Pack in order; mark the last token of the text
      r0  = e3;
      r1  = e3;
      two = 1'b0;
      if (e1_v) begin
         r0 = e1;
         if (e2_v) begin
            r1  = e2;
            two = 1'b1;
         end else if (e3_v) begin
            two = 1'b1;
         end
      end else if (e2_v) begin
         r0 = e2;
      end
      if (fin) begin
         if (two) begin
            r1.done = 1'b1;
         end else begin
            r0.done = 1'b1;
         end
      end
   end

   // Output register with one pending slot for the second token of a byte
   always_comb begin
      out_in      = out_ff;
      pend_in     = pend_ff;
      out_vld_in  = out_vld_ff && !rsp_bus.ready;
      pend_vld_in = pend_vld_ff;
      if (pend_vld_ff && out_free) begin
         out_in      = pend_ff;
         out_vld_in  = 1'b1;
         pend_vld_in = 1'b0;
      end else if (pop && (e1_v || e2_v || e3_v)) begin
         out_in      = r0;
         out_vld_in  = 1'b1;
         pend_in     = r1;
         pend_vld_in = two;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_IDLE;
         st_ff       <= '0;
         out_vld_ff  <= 1'b0;
         pend_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         pend_vld_ff <= pend_vld_in;
         if (pop) begin
            // Return to the start of a new text after its last byte
            mode_ff <= fin ? MODE_IDLE : mode_in;
            st_ff   <= fin ? '0 : st_in;
         end
      end
      out_ff  <= out_in;
      pend_ff <= pend_in;
   end

   assign rsp_bus.valid        = out_vld_ff;
   assign rsp_bus.token_kind   = out_ff.kind;
   assign rsp_bus.token_start  = out_ff.start;
   assign rsp_bus.token_length = out_ff.length;
   assign rsp_bus.text_done    = out_ff.done;

   `CMDLX_ASSERT_IMPL(a_pend_behind_out, reset, pend_vld_ff, out_vld_ff, "pend without out")
   `CMDLX_ASSERT_IMPL(a_pend_not_after_done, reset, pend_vld_ff, !out_ff.done, "pend after done")
   `CMDLX_ASSERT_NEXT(a_final_idle, reset, pop && fin, mode_ff == MODE_IDLE, "mode not cleared")
   `CMDLX_ASSERT_NEXT(a_final_start, reset, pop && fin, st_ff == '0, "start not cleared")
   `CMDLX_ASSERT_IMPL(a_final_emits, reset, pop && fin, e1_v || e2_v || e3_v, "no token at end")

endmodule

// ===== hw/rtl/command_text_lexer.sv =====
// Command text lexer: splits ASCII command text into tokens.
// req_bus carries one byte per transaction (char_byte, is_final marks the last
// byte of a text). rsp_bus carries tokens: token_kind, token_start, token_length
// and text_done, which is set on the last token of each text (a kind-none token
// if its last byte yields no other token). A byte yields zero, one or two tokens.
// Throughput: one byte per cycle while rsp_bus takes tokens and no byte yields
// two tokens; such a byte holds the token engine until its second token moves
// from the pending slot into the single output register. A byte is registered
// in the classifier register, then in the queue, and its first token in the
// token engine's output register; a second token follows from the pending slot.
// A four-entry queue between classifier and token engine lets either side stall.
// When rsp_bus stalls, tokens are held; the queue fills and req_bus.ready drops
// about five bytes later. Offsets saturate at MAX_TEXT_BYTES - 1.
// Reset (synchronous, active high) empties the queue and output register and
// starts a new text at offset zero.
module command_text_lexer import cmdlx_pkg::*; #(
   parameter int MAX_TEXT_BYTES = 4096
) (
   input logic          clock,
   input logic          reset,
   cmdlx_req_if.sink    req_bus,
   cmdlx_rsp_if.source  rsp_bus
);

   localparam int OFF_W  = $clog2(MAX_TEXT_BYTES);
   localparam int DATA_W = CLS_W + OFF_W + 1;

   logic              f_valid, f_ready;
   logic [DATA_W-1:0] f_data;
   logic              b_valid, b_ready;
   logic [DATA_W-1:0] b_data;

   // Classify bytes and attach offsets
   cmdlx_front #(
      .MAX_TEXT_BYTES (MAX_TEXT_BYTES),
      .OFF_W          (OFF_W),
      .DATA_W         (DATA_W)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .q_valid (f_valid),
      .q_ready (f_ready),
      .q_data  (f_data)
   );

   // Decouple classifier from token engine
   cmdlx_queue #(
      .DATA_W (DATA_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (f_data),
      .out_valid (b_valid),
      .out_ready (b_ready),
      .out_data  (b_data)
   );

   // Track the open token and emit results
   cmdlx_back #(
      .OFF_W  (OFF_W),
      .DATA_W (DATA_W)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (b_valid),
      .q_ready (b_ready),
      .q_data  (b_data),
      .rsp_bus (rsp_bus)
   );

endmodule
